// ===== hdl/lru_block_slot_cache_defines.svh =====
// assertion macros for the lru slot cache, clocked on clk_i, held off in reset
`ifndef LRU_BLOCK_SLOT_CACHE_DEFINES_SVH
`define LRU_BLOCK_SLOT_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
`define LBSC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbsc assertion failed");
`define LBSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbsc assertion failed");
`else
`define LBSC_ASSERT_IMPL(name, ante, cons)
`define LBSC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hdl/lbsc_pkg.sv =====
`default_nettype none

package lbsc_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int KEY_WIDTH = 32;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int USE_W = (CNT_W > 7) ? CNT_W : 7;

  localparam int IN_KEY_W   = 32;
  localparam int OUT_SLOT_W = 6;
  localparam int OUT_OFFS_W = 22;
  localparam int SLOT_CNT_W = 7;
  localparam int BLK_SIZE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_UPD
  } lbsc_state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                 cmp;
    logic                 sel;
    logic                 upd;
    logic                 op;
    logic                 fill_mode;
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_W-1:0]     fill;
    logic [CNT_W-1:0]     thr;
  } lbsc_ctrl_t;

  // passed from cell to cell along the row
  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     idx;
    logic [KEY_WIDTH-1:0] key;
    logic [IDX_W-1:0]     rank;
  } lbsc_chain_t;

endpackage

`default_nettype wire

// ===== hdl/lbsc_cell.sv =====
`default_nettype none

module lbsc_cell (
  input  logic                 clk_i,
  input  logic [lbsc_pkg::IDX_W-1:0] idx_i,
  input  lbsc_pkg::lbsc_ctrl_t ctrl_i,
  input  lbsc_pkg::lbsc_chain_t chain_i,
  output lbsc_pkg::lbsc_chain_t chain_o
);
  import lbsc_pkg::*;

  logic [KEY_WIDTH-1:0] key_q;
  logic [IDX_W-1:0]     rank_q;
  logic                 match_q;
  logic                 lru_q;
  logic                 sel_q;
  logic                 filled;
  logic                 sel;
  logic [CNT_W-1:0]     rank_ext;

  assign rank_ext = CNT_W'(rank_q);
  assign filled   = CNT_W'(idx_i) < ctrl_i.fill;

  always_comb begin
    if (ctrl_i.op == OP_INSERT) begin
      sel = ctrl_i.fill_mode ? (CNT_W'(idx_i) == ctrl_i.fill) : lru_q;
    end else begin
      // lowest matching slot wins
      sel = match_q & ~chain_i.hit;
    end
  end

  assign chain_o.hit  = chain_i.hit | match_q;
  assign chain_o.idx  = chain_i.idx | (sel ? idx_i : '0);
  assign chain_o.key  = chain_i.key | (sel ? key_q : '0);
  assign chain_o.rank = chain_i.rank | (sel ? rank_q : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      match_q <= filled && (key_q == ctrl_i.key);
      lru_q   <= filled && (rank_ext == ctrl_i.fill - CNT_W'(1));
    end
    if (ctrl_i.sel) begin
      sel_q <= sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      if (sel_q) begin
        rank_q <= '0;
        if (ctrl_i.op == OP_INSERT) begin
          key_q <= ctrl_i.key;
        end
      end else if (filled && (rank_ext < ctrl_i.thr)) begin
        rank_q <= rank_q + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lru_block_slot_cache.sv =====
`default_nettype none
`include "lru_block_slot_cache_defines.svh"

// Fully associative slot directory with least-recently-used replacement, built
// as a row of cells, one per slot, each holding its key and recency rank. After
// the accept edge an item spends a compare cycle in which every cell matches the
// key and spots the oldest slot, a select cycle in which the hit and the chosen
// slot ripple along the row of cells, and an update cycle that ages the ranks
// on an insert or a hit, writes the key on an insert and registers the result
// with its byte offset. The next item is taken in the cycle after the update, so
// items are handled one at a time, and a new one is taken even while the result
// waits to be taken; the update cycle holds while an earlier result is still
// stalled. Lookups of keys that were never inserted simply miss; slot contents
// need no clearing after reset.
module lru_block_slot_cache (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 in_operation_i,
  input  logic signed [lbsc_pkg::IN_KEY_W-1:0] in_key_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 out_found_o,
  output logic [lbsc_pkg::OUT_SLOT_W-1:0]      out_slot_index_o,
  output logic [lbsc_pkg::OUT_OFFS_W-1:0]      out_byte_offset_o,
  output logic                                 out_evicted_o,
  output logic signed [lbsc_pkg::IN_KEY_W-1:0] out_evicted_key_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lbsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lbsc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import lbsc_pkg::*;

  lbsc_state_e state_q, state_d;

  logic [SLOT_CNT_W-1:0] slot_count_q;
  logic [BLK_SIZE_W-1:0] block_size_q;
  logic [CNT_W-1:0]      fill_q;
  logic                  op_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic                  fill_mode_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      sel_idx_q;
  logic [KEY_WIDTH-1:0]  sel_key_q;
  logic [IDX_W-1:0]      sel_rank_q;

  logic                  out_valid_q;
  logic                  out_found_q;
  logic [OUT_SLOT_W-1:0] out_slot_q;
  logic [OUT_OFFS_W-1:0] out_offs_q;
  logic                  out_evicted_q;
  logic [IN_KEY_W-1:0]   out_evk_q;

  logic                  accepted;
  logic                  out_free;
  logic                  out_load;
  logic [USE_W-1:0]      usable;
  logic                  fill_mode;
  logic                  res_found;
  logic                  res_evicted;
  logic [OUT_SLOT_W-1:0] res_slot;

  lbsc_ctrl_t  ctrl;
  lbsc_chain_t chain [NUM_SLOTS+1];

  assign accepted = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_CNT_W'(64);
      block_size_q <= BLK_SIZE_W'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SLOT_COUNT: slot_count_q <= cfg_data_i[SLOT_CNT_W-1:0];
        REG_BLOCK_SIZE: block_size_q <= cfg_data_i[BLK_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // slot count saturated into one..all slots
  always_comb begin
    if (slot_count_q == '0) begin
      usable = USE_W'(1);
    end else if (USE_W'(slot_count_q) > USE_W'(NUM_SLOTS)) begin
      usable = USE_W'(NUM_SLOTS);
    end else begin
      usable = USE_W'(slot_count_q);
    end
  end
  assign fill_mode = USE_W'(fill_q) < usable;

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_SEL;
      S_SEL:   state_d = S_UPD;
      S_UPD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = 1'b1;
    out_load       = 1'b0;
    ctrl.cmp       = 1'b0;
    ctrl.sel       = 1'b0;
    ctrl.upd       = 1'b0;
    ctrl.op        = op_q;
    ctrl.fill_mode = fill_mode_q;
    ctrl.key       = key_q;
    ctrl.fill      = fill_q;
    ctrl.thr       = (op_q && fill_mode_q) ? fill_q : CNT_W'(sel_rank_q);
    unique case (state_q)
      S_IDLE: in_stall_o = 1'b0;
      S_CMP:  ctrl.cmp = 1'b1;
      S_SEL:  ctrl.sel = 1'b1;
      S_UPD: begin
        out_load = out_free;
        ctrl.upd = out_free && (op_q || hit_q);
      end
      default: ;
    endcase
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (accepted) begin
      op_q  <= in_operation_i;
      key_q <= KEY_WIDTH'(in_key_i);
    end
    if (ctrl.cmp) begin
      fill_mode_q <= fill_mode;
    end
    if (ctrl.sel) begin
      hit_q      <= chain[NUM_SLOTS].hit;
      sel_idx_q  <= chain[NUM_SLOTS].idx;
      sel_key_q  <= chain[NUM_SLOTS].key;
      sel_rank_q <= chain[NUM_SLOTS].rank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl.upd && op_q && fill_mode_q) begin
      fill_q <= fill_q + CNT_W'(1);
    end
  end

  // row of cells
  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    lbsc_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .chain_i (chain[i]),
      .chain_o (chain[i+1])
    );
  end

  // result register
  assign res_found   = op_q || hit_q;
  assign res_evicted = op_q && !fill_mode_q;
  assign res_slot    = res_found ? OUT_SLOT_W'(sel_idx_q) : '0;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q   <= res_found;
      out_slot_q    <= res_slot;
      out_offs_q    <= OUT_OFFS_W'(res_slot) * OUT_OFFS_W'(block_size_q);
      out_evicted_q <= res_evicted;
      out_evk_q     <= res_evicted ? IN_KEY_W'(sel_key_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_found_o       = out_found_q;
  assign out_slot_index_o  = out_slot_q;
  assign out_byte_offset_o = out_offs_q;
  assign out_evicted_o     = out_evicted_q;
  assign out_evicted_key_o = out_evk_q;

  `LBSC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CNT_W'(NUM_SLOTS))
  `LBSC_ASSERT_NEXT(a_accept_starts, accepted, state_q == S_CMP)
  `LBSC_ASSERT_IMPL(a_load_free, out_load, !out_valid_q || !out_stall_i)
  `LBSC_ASSERT_IMPL(a_evict_found, out_valid_o && out_evicted_o, out_found_o)

endmodule

`default_nettype wire
